FILE: rtl/ethernet_l4_packet_filter_core_macros.svh
// assertion macros used by the packet filter top level
`ifndef ETHERNET_L4_PACKET_FILTER_CORE_MACROS_SVH
`define ETHERNET_L4_PACKET_FILTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition must never be true outside reset
`define ELPF_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
// antecedent implies consequent in the same cycle
`define ELPF_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication violated");
`else
`define ELPF_ASSERT_NEVER(label, cond)
`define ELPF_ASSERT_IMPLIES(label, ante, cons)
`endif

`endif

FILE: rtl/elpf_pkg.sv
// shared types and codes of the packet filter
`default_nettype none

package elpf_pkg;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_IPV4    = 2'd1,
    KIND_IPV6    = 2'd2,
    KIND_ARP     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CLS_TCP   = 3'd0,
    CLS_UDP   = 3'd1,
    CLS_ICMP  = 3'd2,
    CLS_ARP   = 3'd3,
    CLS_OTHER = 3'd4
  } class_e;

  // configuration register indexes
  localparam logic [2:0] REG_PROTOCOL_MASK = 3'd0;
  localparam logic [2:0] REG_PORT_FILTER   = 3'd1;
  localparam logic [2:0] REG_FILTER_PORT   = 3'd2;
  localparam logic [2:0] REG_COOKED_MODE   = 3'd3;
  localparam logic [2:0] REG_PACKET_LIMIT  = 3'd4;

  localparam logic [7:0] ETH_TYPE_HI_IP  = 8'h08;
  localparam logic [7:0] ETH_TYPE_LO_V4  = 8'h00;
  localparam logic [7:0] ETH_TYPE_LO_ARP = 8'h06;
  localparam logic [7:0] ETH_TYPE_HI_V6  = 8'h86;
  localparam logic [7:0] ETH_TYPE_LO_V6  = 8'hdd;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [6:0] ETH_HDR_BYTES  = 7'd14;
  localparam logic [6:0] IPV6_L4_OFFSET = 7'd54;

  // per-frame summary from the parser to the verdict stage
  typedef struct packed {
    class_e      cls;
    logic        ipv6;
    logic        len_ok;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] length;
  } summary_t;

  // live filter settings
  typedef struct packed {
    logic [3:0]  mask;
    logic        port_en;
    logic [15:0] port;
  } filt_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/ethernet_l4_packet_filter_core.sv
// top level of the ethernet l4 packet filter: config registers and stage wiring
//
//   channel   handshake          words
//   --------  -----------------  ------------------------------------------
//   input     push / full        data_byte_i, last_byte_i (one frame byte)
//   result    empty / pop        accepted_o .. capture_done_o (one verdict)
//   config    cfg_we_i           cfg_index_i, cfg_data_i (no wait)
//
// one input word is taken every cycle while full is low
// a frame's summary is written into the summary queue, then registered as its verdict
// full rises only when the two-entry summary queue is full while results stall
// reset clears the parser, the queue and the countdown (to 1) and sets the config
// registers to their defaults (mask all ones); no clearing pass
`default_nettype none
`include "ethernet_l4_packet_filter_core_macros.svh"

module ethernet_l4_packet_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        accepted_o,
  output logic [2:0]  packet_class_o,
  output logic        ipv6_flag_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [15:0] packet_length_o,
  output logic        capture_done_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import elpf_pkg::*;

  // configuration registers
  logic [3:0]  mask_q;
  logic        port_en_q;
  logic [15:0] port_q;
  logic        cooked_q;
  logic        reload;
  filt_cfg_t   filt_cfg;

  // front to back
  logic        byte_take;
  logic        sum_valid;
  summary_t    sum_wr;
  summary_t    sum_rd;
  logic        q_valid;
  logic        q_full;
  logic        sum_take;
  logic        out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= 4'hf;
      port_en_q <= 1'b0;
      port_q    <= '0;
      cooked_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PROTOCOL_MASK: mask_q    <= cfg_data_i[3:0];
        REG_PORT_FILTER:   port_en_q <= cfg_data_i[0];
        REG_FILTER_PORT:   port_q    <= cfg_data_i[15:0];
        REG_COOKED_MODE:   cooked_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // limit writes reload the countdown held in the verdict stage
  assign reload           = cfg_we_i && (cfg_index_i == REG_PACKET_LIMIT);
  assign filt_cfg.mask    = mask_q;
  assign filt_cfg.port_en = port_en_q;
  assign filt_cfg.port    = port_q;

  // input side stalls only when a frame summary has nowhere to go
  assign full      = q_full;
  assign byte_take = push && !q_full;

  elpf_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cooked_i     (cooked_q),
    .byte_valid_i (byte_take),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .sum_valid_o  (sum_valid),
    .sum_o        (sum_wr)
  );

  elpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (sum_valid),
    .wdata_i (sum_wr),
    .rd_i    (sum_take),
    .rdata_o (sum_rd),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  elpf_verdict u_verdict (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (filt_cfg),
    .reload_i        (reload),
    .reload_value_i  (cfg_data_i),
    .sum_valid_i     (q_valid),
    .sum_i           (sum_rd),
    .sum_take_o      (sum_take),
    .pop_i           (pop),
    .out_valid_o     (out_valid),
    .accepted_o      (accepted_o),
    .packet_class_o  (packet_class_o),
    .ipv6_flag_o     (ipv6_flag_o),
    .source_port_o   (source_port_o),
    .dest_port_o     (dest_port_o),
    .packet_length_o (packet_length_o),
    .capture_done_o  (capture_done_o)
  );

  // result side: output register of the verdict stage
  assign empty = !out_valid;

  // a summary is never written into a full queue
  `ELPF_ASSERT_NEVER(a_queue_no_overflow, sum_valid && q_full)
  // only a recognized class can be accepted
  `ELPF_ASSERT_IMPLIES(a_accept_has_class, !empty && accepted_o, packet_class_o != CLS_OTHER)
  // ports are reported only for tcp and udp
  `ELPF_ASSERT_IMPLIES(a_ports_only_l4, !empty && packet_class_o != CLS_TCP && packet_class_o != CLS_UDP, source_port_o == 16'd0 && dest_port_o == 16'd0)
  // a frame leaves the queue in the cycle it is judged, and only while the queue holds one
  `ELPF_ASSERT_IMPLIES(a_take_fills_output, sum_take, q_valid)

endmodule

`default_nettype wire

FILE: rtl/elpf_parse.sv
// front end: per-byte header parser and frame classifier
`default_nettype none

module elpf_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cooked_i,
  input  logic               byte_valid_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               sum_valid_o,
  output elpf_pkg::summary_t sum_o
);
  import elpf_pkg::*;

  logic [15:0] pos_q, pos_d, pos_n;
  kind_e       kind_q, kind_d, kind_n;
  logic [5:0]  ihb_q, ihb_d, ihb_n;
  logic [7:0]  nproto_q, nproto_d, nproto_n;
  logic [15:0] sport_q, sport_d, sport_n;
  logic [15:0] dport_q, dport_d, dport_n;

  logic [15:0] skip;
  logic        in_eth;
  logic [15:0] e;
  logic [6:0]  l4;
  logic [15:0] l4_w;
  logic        is_ip;
  logic [15:0] elen;
  kind_e       kind_f;
  class_e      cls;
  logic        l4_cls;
  logic        len_ok;

  always_comb begin
    skip   = cooked_i ? 16'd2 : 16'd0;
    in_eth = (pos_q >= skip);
    e      = pos_q - skip;

    kind_n   = kind_q;
    nproto_n = nproto_q;
    ihb_n    = ihb_q;
    if (in_eth && (e == 16'd12)) begin
      nproto_n = data_byte_i;
    end
    if (in_eth && (e == 16'd13)) begin
      if (nproto_q == ETH_TYPE_HI_IP && data_byte_i == ETH_TYPE_LO_V4) begin
        kind_n = KIND_IPV4;
      end else if (nproto_q == ETH_TYPE_HI_V6 && data_byte_i == ETH_TYPE_LO_V6) begin
        kind_n = KIND_IPV6;
      end else if (nproto_q == ETH_TYPE_HI_IP && data_byte_i == ETH_TYPE_LO_ARP) begin
        kind_n = KIND_ARP;
      end else begin
        kind_n = KIND_UNKNOWN;
      end
    end
    if (in_eth && kind_n == KIND_IPV4 && e == 16'd14) begin
      ihb_n = {data_byte_i[3:0], 2'b00};
    end
    if (in_eth && ((kind_n == KIND_IPV4 && e == 16'd23) ||
                   (kind_n == KIND_IPV6 && e == 16'd20))) begin
      nproto_n = data_byte_i;
    end

    // transport header offset, ihl may be below five
    l4    = (kind_n == KIND_IPV4) ? (ETH_HDR_BYTES + {1'b0, ihb_n}) : IPV6_L4_OFFSET;
    l4_w  = {9'd0, l4};
    is_ip = (kind_n == KIND_IPV4) || (kind_n == KIND_IPV6);

    sport_n = sport_q;
    dport_n = dport_q;
    if (in_eth && is_ip) begin
      if (e == l4_w) begin
        sport_n = {data_byte_i, sport_q[7:0]};
      end else if (e == l4_w + 16'd1) begin
        sport_n = {sport_q[15:8], data_byte_i};
      end else if (e == l4_w + 16'd2) begin
        dport_n = {data_byte_i, dport_q[7:0]};
      end else if (e == l4_w + 16'd3) begin
        dport_n = {dport_q[15:8], data_byte_i};
      end
    end

    pos_n = (pos_q == 16'hffff) ? pos_q : pos_q + 16'd1;

    // frame end classification
    elen   = (pos_n >= skip) ? (pos_n - skip) : 16'd0;
    kind_f = (elen >= 16'd14) ? kind_n : KIND_UNKNOWN;
    cls    = CLS_OTHER;
    if (kind_f == KIND_ARP) begin
      cls = CLS_ARP;
    end else if ((kind_f == KIND_IPV4 && elen >= 16'd24) ||
                 (kind_f == KIND_IPV6 && elen >= 16'd21)) begin
      if (nproto_n == PROTO_TCP) begin
        cls = CLS_TCP;
      end else if (nproto_n == PROTO_UDP) begin
        cls = CLS_UDP;
      end else if (kind_f == KIND_IPV4 && nproto_n == PROTO_ICMP) begin
        cls = CLS_ICMP;
      end else if (kind_f == KIND_IPV6 && nproto_n == PROTO_ICMPV6) begin
        cls = CLS_ICMP;
      end
    end
    l4_cls = (cls == CLS_TCP) || (cls == CLS_UDP);
    len_ok = !l4_cls || (elen >= l4_w + 16'd4);

    sum_o.cls    = cls;
    sum_o.ipv6   = (kind_f == KIND_IPV6);
    sum_o.len_ok = len_ok;
    sum_o.sport  = (l4_cls && len_ok) ? sport_n : 16'd0;
    sum_o.dport  = (l4_cls && len_ok) ? dport_n : 16'd0;
    sum_o.length = pos_n;
    sum_valid_o  = byte_valid_i && last_byte_i;

    if (last_byte_i) begin
      pos_d    = '0;
      kind_d   = KIND_UNKNOWN;
      ihb_d    = '0;
      nproto_d = '0;
      sport_d  = '0;
      dport_d  = '0;
    end else begin
      pos_d    = pos_n;
      kind_d   = kind_n;
      ihb_d    = ihb_n;
      nproto_d = nproto_n;
      sport_d  = sport_n;
      dport_d  = dport_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      kind_q   <= KIND_UNKNOWN;
      ihb_q    <= '0;
      nproto_q <= '0;
      sport_q  <= '0;
      dport_q  <= '0;
    end else if (byte_valid_i) begin
      pos_q    <= pos_d;
      kind_q   <= kind_d;
      ihb_q    <= ihb_d;
      nproto_q <= nproto_d;
      sport_q  <= sport_d;
      dport_q  <= dport_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/elpf_queue.sv
// two-entry queue of frame summaries between parser and verdict stage
`default_nettype none

module elpf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  elpf_pkg::summary_t wdata_i,
  input  logic               rd_i,
  output elpf_pkg::summary_t rdata_o,
  output logic               valid_o,
  output logic               full_o
);
  import elpf_pkg::*;

  summary_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr, do_rd;

  always_comb begin
    valid_o = (cnt_q != 2'd0);
    full_o  = (cnt_q == 2'd2);
    do_wr   = wr_i && !full_o;
    do_rd   = rd_i && valid_o;
    rdata_o = mem_q[rptr_q];
    cnt_d   = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= ~wptr_q;
      end
      if (do_rd) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/elpf_verdict.sv
// back end: class mask, port match, accept countdown and result register
`default_nettype none

module elpf_verdict (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  elpf_pkg::filt_cfg_t cfg_i,
  input  logic                reload_i,
  input  logic [23:0]         reload_value_i,
  input  logic                sum_valid_i,
  input  elpf_pkg::summary_t  sum_i,
  output logic                sum_take_o,
  input  logic                pop_i,
  output logic                out_valid_o,
  output logic                accepted_o,
  output logic [2:0]          packet_class_o,
  output logic                ipv6_flag_o,
  output logic [15:0]         source_port_o,
  output logic [15:0]         dest_port_o,
  output logic [15:0]         packet_length_o,
  output logic                capture_done_o
);
  import elpf_pkg::*;

  logic [23:0] frames_q, frames_d, frames_after;
  logic        out_valid_q, out_valid_d;
  logic        acc_q;
  class_e      cls_q;
  logic        v6_q;
  logic [15:0] sp_q, dp_q, len_q;
  logic        done_q;

  logic [3:0]  mask_eff;
  logic        class_ok, ports_ok, acc, is_l4;

  always_comb begin
    mask_eff = (cfg_i.mask == 4'd0) ? 4'hf : cfg_i.mask;
    case (sum_i.cls)
      CLS_TCP:  class_ok = mask_eff[3];
      CLS_UDP:  class_ok = mask_eff[2];
      CLS_ARP:  class_ok = mask_eff[1];
      CLS_ICMP: class_ok = mask_eff[0];
      default:  class_ok = 1'b0;
    endcase
    is_l4    = (sum_i.cls == CLS_TCP) || (sum_i.cls == CLS_UDP);
    ports_ok = !is_l4 || (sum_i.len_ok && (!cfg_i.port_en ||
               sum_i.sport == cfg_i.port || sum_i.dport == cfg_i.port));
    acc      = class_ok && ports_ok && (frames_q != 24'd0);

    sum_take_o   = sum_valid_i && (!out_valid_q || pop_i);
    frames_after = (sum_take_o && acc) ? frames_q - 24'd1 : frames_q;
    frames_d     = reload_i ? reload_value_i : frames_after;

    if (sum_take_o) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= 24'd1;
      out_valid_q <= 1'b0;
    end else begin
      frames_q    <= frames_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_take_o) begin
      acc_q  <= acc;
      cls_q  <= sum_i.cls;
      v6_q   <= sum_i.ipv6;
      sp_q   <= sum_i.sport;
      dp_q   <= sum_i.dport;
      len_q  <= sum_i.length;
      done_q <= (frames_after == 24'd0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = acc_q;
  assign packet_class_o  = cls_q;
  assign ipv6_flag_o     = v6_q;
  assign source_port_o   = sp_q;
  assign dest_port_o     = dp_q;
  assign packet_length_o = len_q;
  assign capture_done_o  = done_q;

endmodule

`default_nettype wire
